>>> hw/rtl/e2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package e2c_pkg;

  localparam int unsigned PC_W    = 4;
  localparam int unsigned REM_W   = 18;
  localparam int unsigned DIG_W   = 13;
  localparam int unsigned NUM_W   = REM_W + DIG_W;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam int unsigned DLEFT_W = 18;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned CY_W    = 9;

  localparam logic [CY_W-1:0]   CY_START   = 9'd370;
  localparam logic [CY_W-1:0]   CY_LAST    = 9'd399;
  localparam logic [YEAR_W-1:0] YEAR_START = 12'd70;
  localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = 12'd400;
  localparam logic [3:0]        MONTH_LAST = 4'd11;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIV,
    OP_SAVE_SEC,
    OP_SAVE_MIN,
    OP_SAVE_HR,
    OP_SAVE_WDAY,
    OP_SAVE_CYCLE,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_DIV_BUSY,
    COND_YEAR_MORE,
    COND_MONTH_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7,
    DIV_400Y
  } dsel_e;

  typedef struct packed {
    op_e             op;
    dsel_e           dsel;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic div_last;
    logic year_more;
    logic month_more;
  } status_t;

  typedef struct packed {
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [2:0]        weekday;
    logic [YEAR_W-1:0] year_offset;
    logic [3:0]        month_index;
    logic [4:0]        day_of_month;
  } calendar_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_IDLE, dsel: DIV_60, cond: COND_NEVER, target: '0, last: 1'b1};
    case (pc)
      4'd0:  w = '{OP_IDLE,       DIV_60,   COND_NO_REQ,     4'd0,  1'b0};
      4'd1:  w = '{OP_DIV,        DIV_60,   COND_DIV_BUSY,   4'd1,  1'b0};
      4'd2:  w = '{OP_SAVE_SEC,   DIV_60,   COND_NEVER,      4'd0,  1'b0};
      4'd3:  w = '{OP_DIV,        DIV_60,   COND_DIV_BUSY,   4'd3,  1'b0};
      4'd4:  w = '{OP_SAVE_MIN,   DIV_60,   COND_NEVER,      4'd0,  1'b0};
      4'd5:  w = '{OP_DIV,        DIV_24,   COND_DIV_BUSY,   4'd5,  1'b0};
      4'd6:  w = '{OP_SAVE_HR,    DIV_24,   COND_NEVER,      4'd0,  1'b0};
      4'd7:  w = '{OP_DIV,        DIV_7,    COND_DIV_BUSY,   4'd7,  1'b0};
      4'd8:  w = '{OP_SAVE_WDAY,  DIV_7,    COND_NEVER,      4'd0,  1'b0};
      4'd9:  w = '{OP_DIV,        DIV_400Y, COND_DIV_BUSY,   4'd9,  1'b0};
      4'd10: w = '{OP_SAVE_CYCLE, DIV_400Y, COND_NEVER,      4'd0,  1'b0};
      4'd11: w = '{OP_YEAR,       DIV_60,   COND_YEAR_MORE,  4'd11, 1'b0};
      4'd12: w = '{OP_MONTH,      DIV_60,   COND_MONTH_MORE, 4'd12, 1'b0};
      4'd13: w = '{OP_DONE,       DIV_60,   COND_OUT_BUSY,   4'd13, 1'b1};
      default: w = '{OP_IDLE,     DIV_60,   COND_NEVER,      4'd0,  1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] divisor(input dsel_e sel);
    logic [REM_W-1:0] d;
    case (sel)
      DIV_60:   d = 18'd60;
      DIV_24:   d = 18'd24;
      DIV_7:    d = 18'd7;
      DIV_400Y: d = 18'd146097;
      default:  d = 18'd60;
    endcase
    return d;
  endfunction

  // quotient digit of a NUM_W-bit partial dividend: m = ceil(2^s / d) with
  // s = NUM_W + ceil(log2 d), exact over the whole NUM_W-bit range
  function automatic logic [DIG_W-1:0] recip_digit(input dsel_e sel,
                                                   input logic [NUM_W-1:0] num);
    logic [RECIP_W-1:0] m;
    logic [PROD_W-1:0]  p;
    logic [DIG_W-1:0]   q;
    case (sel)
      DIV_60:   m = 32'd2290649225;
      DIV_24:   m = 32'd2863311531;
      DIV_7:    m = 32'd2454267027;
      DIV_400Y: m = 32'd3853261556;
      default:  m = 32'd2290649225;
    endcase
    p = PROD_W'(num) * PROD_W'(m);
    case (sel)
      DIV_60:   q = p[37 +: DIG_W];
      DIV_24:   q = p[36 +: DIG_W];
      DIV_7:    q = p[34 +: DIG_W];
      DIV_400Y: q = p[49 +: DIG_W];
      default:  q = p[37 +: DIG_W];
    endcase
    return q;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
      4'd1:                                     len = leap ? 5'd29 : 5'd28;
      default:                                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/e2c_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface e2c_seconds_if #(
  parameter int unsigned SECONDS_WIDTH = 36
);
  logic                     valid;
  logic                     ready;
  logic [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_calendar_if;
  logic        valid;
  logic        ready;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [11:0] year_offset;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;

  modport source (
    output valid, output second, output minute, output hour, output weekday,
    output year_offset, output month_index, output day_of_month, input ready
  );
  modport sink (
    input valid, input second, input minute, input hour, input weekday,
    input year_offset, input month_index, input day_of_month, output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts unsigned seconds since 1970-01-01 00:00:00 UTC into UTC second, minute, hour,
// weekday (Sunday 0), year minus 1900, month (0..11) and day of month. One request is
// converted at a time. The conversion steps through each whole year left within the
// 400-year cycle (up to 399) and then each whole month (up to 11). The five divisions
// by 60, 60, 24, 7 and the 400-year day count run 13 bits at a time by reciprocal
// multiplication. The next request can be taken in the cycle after the result is
// loaded; the year loop of the microcode takes most of the time per request. The
// result sits in an output register, so the next request is taken while it waits to be
// read; a new result waits in the last step while that register is still full.
module epoch_seconds_to_calendar
  import e2c_pkg::*;
#(
  parameter int unsigned SECONDS_WIDTH = 36
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  e2c_seconds_if.sink   req_i,
  e2c_calendar_if.source rsp_o
);

  ctrl_t     ctrl;
  status_t   status;
  calendar_t cal;

  e2c_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  e2c_datapath #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .in_seconds_i (req_i.epoch_seconds),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_data_o   (cal)
  );

  assign rsp_o.second       = cal.second;
  assign rsp_o.minute       = cal.minute;
  assign rsp_o.hour         = cal.hour;
  assign rsp_o.weekday      = cal.weekday;
  assign rsp_o.year_offset  = cal.year_offset;
  assign rsp_o.month_index  = cal.month_index;
  assign rsp_o.day_of_month = cal.day_of_month;

endmodule

`default_nettype wire

>>> hw/rtl/e2c_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module e2c_sequencer
  import e2c_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            take;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:      take = 1'b0;
      COND_NO_REQ:     take = !status_i.in_valid;
      COND_DIV_BUSY:   take = !status_i.div_last;
      COND_YEAR_MORE:  take = status_i.year_more;
      COND_MONTH_MORE: take = status_i.month_more;
      COND_OUT_BUSY:   take = status_i.out_busy;
      default:         take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_d = ctrl.target;
    end else if (ctrl.last) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/e2c_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module e2c_datapath
  import e2c_pkg::*;
#(
  parameter int unsigned SECONDS_WIDTH = 36
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctrl_t                    ctrl_i,
  output status_t                       status_o,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SECONDS_WIDTH-1:0] in_seconds_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output calendar_t                     out_data_o
);

  localparam int unsigned NDIG  = (SECONDS_WIDTH + DIG_W - 1) / DIG_W;
  localparam int unsigned ACC_W = NDIG * DIG_W;
  localparam int unsigned STEPS = 2 * NDIG;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [ACC_W-1:0]         acc_q, days_q;
  logic [REM_W-1:0]         rem_q;
  logic [DIG_W-1:0]         qdig_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [5:0]               sec_q, min_q;
  logic [4:0]               hr_q;
  logic [2:0]               wday_q;
  logic [DLEFT_W-1:0]       dleft_q;
  logic [YEAR_W-1:0]        yr_q;
  logic [CY_W-1:0]          cy_q;
  logic [3:0]               mon_q;
  logic                     out_valid_q;
  calendar_t                out_q;

  logic [NUM_W-1:0]   num, qd_prod, num_left;
  logic [REM_W-1:0]   dval;
  logic [DIG_W-1:0]   qdig;
  logic               div_last, leap, year_more, month_more, out_busy, accept;
  logic [8:0]         ylen;
  logic [4:0]         mlen;

  // each quotient digit: estimate, then subtract and shift
  assign dval     = divisor(ctrl_i.dsel);
  assign num      = {rem_q, acc_q[ACC_W-1 -: DIG_W]};
  assign qdig     = recip_digit(ctrl_i.dsel, num);
  assign qd_prod  = NUM_W'(qdig_q) * NUM_W'(dval);
  assign num_left = num - qd_prod;
  assign div_last = cnt_q == CNT_W'(STEPS - 1);

  // position within the 400-year cycle, Gregorian leap rule
  assign leap = (cy_q[1:0] == 2'd0) &&
                !(cy_q == 9'd100 || cy_q == 9'd200 || cy_q == 9'd300);
  assign ylen       = leap ? 9'd366 : 9'd365;
  assign mlen       = month_len(mon_q, leap);
  assign year_more  = dleft_q >= DLEFT_W'(ylen);
  assign month_more = (mon_q != MONTH_LAST) && (dleft_q >= DLEFT_W'(mlen));

  assign out_busy   = out_valid_q && !out_ready_i;
  assign in_ready_o = ctrl_i.op == OP_IDLE;
  assign accept     = in_ready_o && in_valid_i;

  assign status_o = '{in_valid: in_valid_i, out_busy: out_busy, div_last: div_last,
                      year_more: year_more, month_more: month_more};

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_IDLE: begin
        if (accept) begin
          acc_q <= ACC_W'(in_seconds_i);
          rem_q <= '0;
          cnt_q <= '0;
        end
      end
      OP_DIV: begin
        if (!cnt_q[0]) begin
          qdig_q <= qdig;
        end else begin
          rem_q <= num_left[REM_W-1:0];
          acc_q <= {acc_q[ACC_W-DIG_W-1:0], qdig_q};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_SAVE_SEC: begin
        sec_q <= rem_q[5:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_SAVE_MIN: begin
        min_q <= rem_q[5:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_SAVE_HR: begin
        hr_q   <= rem_q[4:0];
        days_q <= acc_q;
        acc_q  <= acc_q + ACC_W'(4);
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      OP_SAVE_WDAY: begin
        wday_q <= rem_q[2:0];
        acc_q  <= days_q;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      OP_SAVE_CYCLE: begin
        dleft_q <= rem_q[DLEFT_W-1:0];
        yr_q    <= YEAR_START + YEAR_W'(acc_q[YEAR_W-1:0] * YEARS_PER_CYCLE);
        cy_q    <= CY_START;
        mon_q   <= '0;
      end
      OP_YEAR: begin
        if (year_more) begin
          dleft_q <= dleft_q - DLEFT_W'(ylen);
          yr_q    <= yr_q + YEAR_W'(1);
          cy_q    <= (cy_q == CY_LAST) ? '0 : cy_q + CY_W'(1);
        end
      end
      OP_MONTH: begin
        if (month_more) begin
          dleft_q <= dleft_q - DLEFT_W'(mlen);
          mon_q   <= mon_q + 4'd1;
        end
      end
      OP_DONE: begin
        if (!out_busy) begin
          out_q <= '{second: sec_q, minute: min_q, hour: hr_q, weekday: wday_q,
                     year_offset: yr_q, month_index: mon_q,
                     day_of_month: dleft_q[4:0] + 5'd1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == OP_DONE && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> verif/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;
  import e2c_pkg::*;

  localparam int unsigned SECONDS_W   = 36;
  localparam logic [SECONDS_W-1:0] SECONDS_MAX = '1;
  localparam longint unsigned SECS_PER_DAY = 86400;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned DRAIN_CYCLES = 800;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [SECONDS_W-1:0] secs;
    bit                   fixed;
    calendar_t            want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  e2c_seconds_if #(.SECONDS_WIDTH(SECONDS_W)) req_if ();
  e2c_calendar_if rsp_if ();

  epoch_seconds_to_calendar #(
    .SECONDS_WIDTH(SECONDS_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  calendar_t       calendar_q[$];
  stim_row_t       stim_rows[$];
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     errors;
  longint unsigned cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit is_leap(input longint unsigned year);
    if (year % 400 == 0) return 1'b1;
    if (year % 100 == 0) return 1'b0;
    return (year % 4) == 0;
  endfunction

  function automatic longint unsigned days_in_year(input longint unsigned yoff);
    return is_leap(1900 + yoff) ? 366 : 365;
  endfunction

  function automatic longint unsigned days_in_month(input longint unsigned mon, input bit leap);
    case (mon)
      0, 2, 4, 6, 7, 9, 11: return 31;
      1:                    return leap ? 29 : 28;
      default:              return 30;
    endcase
  endfunction

  function automatic calendar_t to_calendar(input logic [SECONDS_W-1:0] secs);
    longint unsigned t;
    longint unsigned days;
    longint unsigned yr;
    longint unsigned mon;
    calendar_t       c;
    t = secs;
    c.second = 6'(t % 60);
    t = t / 60;
    c.minute = 6'(t % 60);
    t = t / 60;
    c.hour = 5'(t % 24);
    days = t / 24;
    c.weekday = 3'((days + 4) % 7);
    yr = 70 + 400 * (days / 146097);
    days = days % 146097;
    while (days >= days_in_year(yr)) begin
      days = days - days_in_year(yr);
      yr++;
    end
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, is_leap(1900 + yr))) begin
      days = days - days_in_month(mon, is_leap(1900 + yr));
      mon++;
    end
    c.year_offset  = 12'(yr);
    c.month_index  = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  // Seconds at a given date and time of day plus delta, clamped to the input range.
  function automatic logic [SECONDS_W-1:0] secs_at(input longint unsigned yoff,
                                                   input longint unsigned mon,
                                                   input longint unsigned mday,
                                                   input longint unsigned tod,
                                                   input int delta);
    longint unsigned days;
    longint          s;
    days = 0;
    for (longint unsigned y = 70; y < yoff; y++) days += days_in_year(y);
    for (longint unsigned m = 0; m < mon; m++) days += days_in_month(m, is_leap(1900 + yoff));
    days += mday - 1;
    s = longint'(days * SECS_PER_DAY + tod) + delta;
    if (s < 0) s = 0;
    if (s > longint'(SECONDS_MAX)) s = longint'(SECONDS_MAX);
    return SECONDS_W'(s);
  endfunction

  function automatic void add_row(input logic [SECONDS_W-1:0] secs, input bit fixed,
                                  input calendar_t want);
    stim_row_t r;
    r.secs  = secs;
    r.fixed = fixed;
    r.want  = fixed ? want : to_calendar(secs);
    stim_rows.push_back(r);
  endfunction

  function automatic logic [SECONDS_W-1:0] random_seconds();
    int unsigned          kind;
    int unsigned          pick;
    longint unsigned      yoff;
    longint unsigned      mon;
    longint unsigned      mday;
    longint unsigned      tod;
    longint unsigned      centuries[6];
    centuries = '{100, 200, 300, 500, 700, 2100};
    kind = $urandom_range(99);
    if (kind < 35) return {4'($urandom_range(15)), 32'($urandom())};
    if (kind < 50) return {4'd0, 32'($urandom())};
    if ($urandom_range(99) < 30) yoff = centuries[$urandom_range(5)];
    else yoff = $urandom_range(2247, 70);
    mon = $urandom_range(11);
    mday = $urandom_range(1) ? 1 : days_in_month(mon, is_leap(1900 + yoff));
    pick = $urandom_range(2);
    tod = (pick == 0) ? 0 : (pick == 1) ? SECS_PER_DAY - 1 : $urandom_range(86399);
    return secs_at(yoff, mon, mday, tod, int'($urandom_range(2)) - 1);
  endfunction

  task automatic send_request(input logic [SECONDS_W-1:0] secs, input calendar_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid         = 1'b1;
    req_if.epoch_seconds = secs;
    do @(posedge clk); while (!req_if.ready);
    calendar_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_calendar(input calendar_t want, input calendar_t got);
    if (got.second !== want.second) begin
      $error("second: expected %0d, got %0d", want.second, got.second);
      errors++;
    end
    if (got.minute !== want.minute) begin
      $error("minute: expected %0d, got %0d", want.minute, got.minute);
      errors++;
    end
    if (got.hour !== want.hour) begin
      $error("hour: expected %0d, got %0d", want.hour, got.hour);
      errors++;
    end
    if (got.weekday !== want.weekday) begin
      $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
      errors++;
    end
    if (got.year_offset !== want.year_offset) begin
      $error("year_offset: expected %0d, got %0d", want.year_offset, got.year_offset);
      errors++;
    end
    if (got.month_index !== want.month_index) begin
      $error("month_index: expected %0d, got %0d", want.month_index, got.month_index);
      errors++;
    end
    if (got.day_of_month !== want.day_of_month) begin
      $error("day_of_month: expected %0d, got %0d", want.day_of_month, got.day_of_month);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    rsp_if.ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    calendar_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.second, rsp_if.minute, rsp_if.hour, rsp_if.weekday,
              rsp_if.year_offset, rsp_if.month_index, rsp_if.day_of_month};
      if (calendar_q.size() == 0) begin
        $error("unexpected calendar result");
        errors++;
      end else begin
        check_calendar(calendar_q.pop_front(), got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    calendar_t blank;
    blank                = '0;
    errors               = 0;
    cycles               = 0;
    send_idle_pct        = 21;
    recv_idle_pct        = 85;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.epoch_seconds = '0;
    rsp_if.ready         = 1'b0;

    add_row(36'd0,        1'b1, '{6'd0,  6'd0,  5'd0,  3'd4, 12'd70, 4'd0, 5'd1});
    add_row(36'd59,       1'b1, '{6'd59, 6'd0,  5'd0,  3'd4, 12'd70, 4'd0, 5'd1});
    add_row(36'd86399,    1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 12'd70, 4'd0, 5'd1});
    add_row(36'd86400,    1'b1, '{6'd0,  6'd0,  5'd0,  3'd5, 12'd70, 4'd0, 5'd2});
    add_row(36'd31536000, 1'b1, '{6'd0,  6'd0,  5'd0,  3'd5, 12'd71, 4'd0, 5'd1});
    add_row(SECONDS_MAX,           1'b0, blank);
    add_row(36'h8_0000_0000,       1'b0, blank);
    add_row(36'hA_AAAA_AAAA,       1'b0, blank);
    add_row(36'h5_5555_5555,       1'b0, blank);
    add_row(36'h0_FFFF_FFFF,       1'b0, blank);
    add_row(36'h1_0000_0000,       1'b0, blank);
    add_row(secs_at(72, 1, 29, 0, 0),       1'b0, blank);
    add_row(secs_at(72, 11, 31, 86399, 0),  1'b0, blank);
    add_row(secs_at(100, 0, 1, 0, -1),      1'b0, blank);
    add_row(secs_at(100, 0, 1, 0, 0),       1'b0, blank);
    add_row(secs_at(100, 1, 29, 43200, 0),  1'b0, blank);
    add_row(secs_at(200, 1, 28, 86399, 0),  1'b0, blank);
    add_row(secs_at(200, 1, 28, 86399, 1),  1'b0, blank);
    add_row(secs_at(500, 1, 29, 0, 0),      1'b0, blank);
    add_row(secs_at(470, 0, 1, 0, 0),       1'b0, blank);
    add_row(secs_at(469, 11, 31, 86399, 0), 1'b0, blank);
    add_row(secs_at(2247, 0, 1, 0, 0),      1'b0, blank);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) send_request(stim_rows[i].secs, stim_rows[i].want);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      logic [SECONDS_W-1:0] secs;
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 21;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      secs = random_seconds();
      send_request(secs, to_calendar(secs));
    end
    req_if.valid = 1'b0;

    while (calendar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_if.sv
hw/rtl/e2c_sequencer.sv
hw/rtl/e2c_datapath.sv
hw/rtl/epoch_seconds_to_calendar.sv
verif/tb_epoch_seconds_to_calendar.sv
